// ----- hdl/frdet_pkg.sv -----
// shared constants and widths for the frame rms over average detector
// used by the top level, the divider and the square root unit
package frdet_pkg;

  localparam int HISTORY_DEPTH  = 600;
  localparam int MAX_FRAME      = 8192;
  localparam int BASELINE_LEVEL = 1280;
  localparam int FRAC_BITS      = 4;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = SAMPLE_W + 1;
  localparam int SQ_W     = 2 * SAMPLE_W - 1;
  localparam int LEVEL_W  = 20;
  localparam int RUN_W    = 8;

  localparam int COUNT_W  = $clog2(MAX_FRAME + 1);
  localparam int SUM_W    = COUNT_W + SQ_W - 1;
  localparam int HDEPTH_W = $clog2(HISTORY_DEPTH + 1);
  localparam int PTR_W    = $clog2(HISTORY_DEPTH);
  localparam int TOTAL_W  = LEVEL_W + HDEPTH_W;

  localparam int SCALED_W   = SUM_W + 2 * FRAC_BITS;
  localparam int DIVIDEND_W = (SCALED_W > TOTAL_W) ? SCALED_W : TOTAL_W;
  localparam int DIVISOR_W  = (COUNT_W > HDEPTH_W) ? COUNT_W : HDEPTH_W;

  localparam int ROOT_W    = (DIVIDEND_W + 1) / 2;
  localparam int ROOT_IN_W = 2 * ROOT_W;

  // mean of the history as total * ceil(2^s / depth) >> s, exact for any total
  // of TOTAL_W bits when s = TOTAL_W + ceil(log2(depth))
  localparam int MEAN_SHIFT  = TOTAL_W + $clog2(HISTORY_DEPTH);
  localparam int MEAN_PROD_W = 2 * TOTAL_W + 1;
  localparam logic [TOTAL_W:0] MEAN_RECIP =
    (TOTAL_W + 1)'(((64'd1 << MEAN_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1)
                   / 64'(HISTORY_DEPTH));

  localparam logic [TOTAL_W-1:0] RESET_TOTAL =
    TOTAL_W'(HISTORY_DEPTH * BASELINE_LEVEL);

  typedef logic [LEVEL_W-1:0] level_t;

endpackage

// ----- hdl/frame_rms_over_average_detector_top.sv -----
// frame rms over average detector: squares and sums samples, then per frame
// computes the rms, compares it with the mean of a level history memory
// input stalls after each accepted sample while it is accumulated; after a frame_end
// item it stays stalled through the divider and square root until the result is out
// a result still held by the receiver delays the next frame close; input stalls meanwhile
// reset (synchronous): clears sums, pointer, run count, history reads as baseline
module frame_rms_over_average_detector_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [frdet_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                               in_frame_end,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [frdet_pkg::LEVEL_W-1:0]      out_rms_level,
  output logic [frdet_pkg::LEVEL_W-1:0]      out_mean_level,
  output logic [frdet_pkg::RUN_W-1:0]        out_over_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DIV_GO,
    S_DIV_WAIT,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_MUL,
    S_UPD
  } state_t;

  state_t state_r;

  logic [frdet_pkg::SQ_W-1:0]    sq_r;
  logic                          last_r;
  logic [frdet_pkg::SUM_W-1:0]   sum_r;
  logic [frdet_pkg::COUNT_W-1:0] count_r;
  logic [frdet_pkg::TOTAL_W-1:0] total_r;
  logic [frdet_pkg::TOTAL_W-1:0] prod_r;
  logic [frdet_pkg::PTR_W-1:0]   wp_r;
  logic                          wrapped_r;
  logic [frdet_pkg::RUN_W-1:0]   run_r;
  frdet_pkg::level_t             rms_r;
  frdet_pkg::level_t             mean_r;

  logic                          out_valid_r;
  frdet_pkg::level_t             out_rms_r;
  frdet_pkg::level_t             out_mean_r;
  logic [frdet_pkg::RUN_W-1:0]   out_cnt_r;

  // level history memory
  frdet_pkg::level_t hist_mem [frdet_pkg::HISTORY_DEPTH];
  frdet_pkg::level_t hist_q;
  logic              hist_we;

  logic [frdet_pkg::MAG_W-1:0]        mag;
  logic [2*frdet_pkg::MAG_W-1:0]      mag_sq;
  logic                               out_free;
  frdet_pkg::level_t                  old_level;
  logic [frdet_pkg::MEAN_PROD_W-1:0]  mean_prod;

  logic                               div_start;
  logic [frdet_pkg::DIVIDEND_W-1:0]   div_dividend;
  logic [frdet_pkg::DIVISOR_W-1:0]    div_divisor;
  logic                               div_busy;
  logic [frdet_pkg::DIVIDEND_W-1:0]   div_quo;
  logic                               root_start;
  logic                               root_busy;
  logic [frdet_pkg::ROOT_W-1:0]       root_val;

  always_comb begin
    mag = in_sample[frdet_pkg::SAMPLE_W-1]
        ? frdet_pkg::MAG_W'(frdet_pkg::MAG_W'(0) - {in_sample[frdet_pkg::SAMPLE_W-1], in_sample})
        : {1'b0, in_sample};
    mag_sq = mag * mag;
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign hist_we   = (state_r == S_UPD) && out_free;
  // entries not yet written since reset are read as the baseline level
  assign old_level = wrapped_r ? hist_q : frdet_pkg::level_t'(frdet_pkg::BASELINE_LEVEL);

  // mean of the history by reciprocal multiply
  assign mean_prod = frdet_pkg::MEAN_PROD_W'(total_r)
                   * frdet_pkg::MEAN_PROD_W'(frdet_pkg::MEAN_RECIP);

  // the divider forms sum*2^(2f)/count, the root of which is the rms
  always_comb begin
    div_start    = (state_r == S_DIV_GO);
    root_start   = (state_r == S_ROOT_GO);
    div_dividend = frdet_pkg::DIVIDEND_W'(sum_r) << (2 * frdet_pkg::FRAC_BITS);
    div_divisor  = frdet_pkg::DIVISOR_W'(count_r);
  end

  frdet_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  frdet_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (frdet_pkg::ROOT_IN_W'(div_quo)),
    .busy     (root_busy),
    .root     (root_val)
  );

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wp_r] <= rms_r;
    end
    if (state_r == S_MUL) begin
      hist_q <= hist_mem[wp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      count_r     <= '0;
      total_r     <= frdet_pkg::RESET_TOTAL;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      run_r       <= '0;
    end else begin
      if (out_valid_r && !out_stall && !hist_we) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            sq_r    <= frdet_pkg::SQ_W'(mag_sq);
            last_r  <= in_frame_end;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          // samples past the frame limit are dropped from sum and count
          if (count_r < frdet_pkg::COUNT_W'(frdet_pkg::MAX_FRAME)) begin
            sum_r   <= sum_r + frdet_pkg::SUM_W'(sq_r);
            count_r <= count_r + 1'b1;
          end
          state_r <= last_r ? S_DIV_GO : S_IDLE;
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (!div_busy) begin
            state_r <= S_ROOT_GO;
          end
        end
        S_ROOT_GO: begin
          state_r <= S_ROOT_WAIT;
        end
        S_ROOT_WAIT: begin
          if (!div_busy && !root_busy) begin
            rms_r   <= (count_r == '0) ? '0 : root_val[frdet_pkg::LEVEL_W-1:0];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= frdet_pkg::TOTAL_W'(rms_r) * frdet_pkg::TOTAL_W'(frdet_pkg::HISTORY_DEPTH);
          mean_r  <= mean_prod[frdet_pkg::MEAN_SHIFT +: frdet_pkg::LEVEL_W];
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (out_free) begin
            run_r       <= (prod_r > total_r) ? run_r + 1'b1 : '0;
            out_cnt_r   <= (prod_r > total_r) ? run_r + 1'b1 : '0;
            out_rms_r   <= rms_r;
            out_mean_r  <= mean_r;
            out_valid_r <= 1'b1;
            total_r     <= total_r - frdet_pkg::TOTAL_W'(old_level)
                         + frdet_pkg::TOTAL_W'(rms_r);
            if (wp_r == frdet_pkg::PTR_W'(frdet_pkg::HISTORY_DEPTH - 1)) begin
              wp_r      <= '0;
              wrapped_r <= 1'b1;
            end else begin
              wp_r <= wp_r + 1'b1;
            end
            sum_r   <= '0;
            count_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_rms_level  = out_rms_r;
  assign out_mean_level = out_mean_r;
  assign out_over_count = out_cnt_r;

endmodule

// ----- hdl/frdet_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// depends on frdet_pkg for operand widths
module frdet_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [frdet_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [frdet_pkg::DIVISOR_W-1:0]     divisor,
  output logic                                busy,
  output logic [frdet_pkg::DIVIDEND_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(frdet_pkg::DIVIDEND_W + 1);

  logic [frdet_pkg::DIVISOR_W-1:0]  rem_r;
  logic [frdet_pkg::DIVISOR_W-1:0]  dsr_r;
  logic [frdet_pkg::DIVIDEND_W-1:0] quo_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic                             busy_r;

  logic [frdet_pkg::DIVISOR_W:0] rem_sh;
  logic [frdet_pkg::DIVISOR_W:0] diff;
  logic                          fits;

  always_comb begin
    rem_sh = {rem_r, quo_r[frdet_pkg::DIVIDEND_W-1]};
    fits   = rem_sh >= {1'b0, dsr_r};
    diff   = rem_sh - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(frdet_pkg::DIVIDEND_W);
      rem_r  <= '0;
      dsr_r  <= divisor;
      quo_r  <= dividend;
    end else if (busy_r) begin
      // dividend bits shift out the top while quotient bits enter the bottom
      quo_r <= {quo_r[frdet_pkg::DIVIDEND_W-2:0], fits};
      rem_r <= fits ? diff[frdet_pkg::DIVISOR_W-1:0] : rem_sh[frdet_pkg::DIVISOR_W-1:0];
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ----- hdl/frdet_sqrt.sv -----
// iterative integer square root, two radicand bits per cycle
// depends on frdet_pkg for operand widths
module frdet_sqrt (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [frdet_pkg::ROOT_IN_W-1:0]    radicand,
  output logic                               busy,
  output logic [frdet_pkg::ROOT_W-1:0]       root
);

  localparam int RW    = frdet_pkg::ROOT_W;
  localparam int IW    = frdet_pkg::ROOT_IN_W;
  localparam int CNT_W = $clog2(RW + 1);

  logic [IW-1:0]    x_r;
  logic [RW+1:0]    rem_r;
  logic [RW-1:0]    root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;

  logic [RW+3:0] rem_t;
  logic [RW+3:0] trial;
  logic          fits;

  always_comb begin
    rem_t = {rem_r, x_r[IW-1:IW-2]};
    trial = {2'b00, root_r, 2'b01};
    fits  = rem_t >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(RW);
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[IW-3:0], 2'b00};
      rem_r  <= fits ? (RW+2)'(rem_t - trial) : rem_t[RW+1:0];
      root_r <= {root_r[RW-2:0], fits};
      cnt_r  <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

// ----- hdl/frdet_checker.sv -----
// port-level checks for the frame rms over average detector
// bound to frame_rms_over_average_detector_top; uses frdet_pkg widths
module frdet_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic signed [frdet_pkg::SAMPLE_W-1:0] in_sample,
  input logic                                  in_frame_end,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic [frdet_pkg::LEVEL_W-1:0]         out_rms_level,
  input logic [frdet_pkg::LEVEL_W-1:0]         out_mean_level,
  input logic [frdet_pkg::RUN_W-1:0]           out_over_count
);

  logic [frdet_pkg::RUN_W-1:0] prev_cnt_r;
  logic                        in_seen;

  assign in_seen = in_valid && (in_sample == in_sample) && (in_frame_end == in_frame_end);

  // over count of the last delivered item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cnt_r <= '0;
    end else if (out_valid && !out_stall) begin
      prev_cnt_r <= out_over_count;
    end
  end

  // after reset the block takes items and holds no result
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!in_stall && !out_valid))
    else $error("block not idle after reset");

  // a counted frame must have been above the mean
  a_over_above_mean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_over_count != '0) |-> (out_rms_level > out_mean_level))
    else $error("over count set with rms not above mean");

  // the run count either restarts or steps by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_over_count == '0 ||
                   out_over_count == frdet_pkg::RUN_W'(prev_cnt_r + 1'b1)))
    else $error("over count skipped a value");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && !in_seen) || (out_valid && out_stall) |=>
      (out_valid && $stable(out_rms_level) && $stable(out_mean_level)
       && $stable(out_over_count)))
    else $error("stalled result changed");

endmodule

bind frame_rms_over_average_detector_top frdet_checker u_frdet_checker (.*);

// ----- tb/frame_rms_checker.sv -----
// checker for the frame rms over average detector: watches both channels,
// predicts each frame result and compares it field by field
// depends on frdet_pkg for widths and the history, frame and scaling constants
`timescale 1ns / 1ps

module frame_rms_checker
  import frdet_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_frame_end,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [LEVEL_W-1:0]         out_rms_level,
  input  logic [LEVEL_W-1:0]         out_mean_level,
  input  logic [RUN_W-1:0]           out_over_count,
  output int                         mismatches,
  output int                         waiting,
  output int                         samples_taken,
  output int                         frames_done
);

  typedef struct packed {
    level_t           rms;
    level_t           mean;
    logic [RUN_W-1:0] over;
  } frame_result_t;

  frame_result_t    frame_results_q [$];
  logic [63:0]      energy_sum;
  int unsigned      frame_len;
  level_t           level_ring [HISTORY_DEPTH];
  logic [63:0]      ring_total;
  int unsigned      ring_idx;
  logic [RUN_W-1:0] over_run;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    // scaled energy stays below 2^52, so the root fits in 28 bits
    for (int b = 27; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  always @(posedge clk) begin : watch
    frame_result_t want;
    logic [63:0]   mag;
    logic [63:0]   rms64;
    logic [63:0]   mean64;
    if (!rst_n) begin
      frame_results_q.delete();
      energy_sum = '0;
      frame_len  = 0;
      for (int i = 0; i < HISTORY_DEPTH; i++) level_ring[i] = level_t'(BASELINE_LEVEL);
      ring_total    = 64'(HISTORY_DEPTH) * 64'(BASELINE_LEVEL);
      ring_idx      = 0;
      over_run      = '0;
      mismatches    = 0;
      samples_taken = 0;
      frames_done   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_results_q.size() == 0) begin
          $error("result with no frame pending: rms %0d mean %0d count %0d",
                 out_rms_level, out_mean_level, out_over_count);
          mismatches++;
        end else begin
          want = frame_results_q.pop_front();
          if (out_rms_level !== want.rms) begin
            $error("rms_level: expected %0d, got %0d", want.rms, out_rms_level);
            mismatches++;
          end
          if (out_mean_level !== want.mean) begin
            $error("mean_level: expected %0d, got %0d", want.mean, out_mean_level);
            mismatches++;
          end
          if (out_over_count !== want.over) begin
            $error("over_count: expected %0d, got %0d", want.over, out_over_count);
            mismatches++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        samples_taken++;
        mag = in_sample[SAMPLE_W-1] ? 64'(17'h10000 - {1'b0, in_sample})
                                    : 64'(in_sample[SAMPLE_W-2:0]);
        // samples past the frame limit are dropped, a late frame end still closes
        if (frame_len < MAX_FRAME) begin
          energy_sum = energy_sum + mag * mag;
          frame_len++;
        end
        if (in_frame_end) begin
          if (frame_len != 0)
            rms64 = floor_sqrt((energy_sum << (2 * FRAC_BITS)) / 64'(frame_len));
          else
            rms64 = '0;
          rms64  = rms64 & 64'hFFFFF;
          mean64 = ring_total / 64'(HISTORY_DEPTH);
          if (rms64 * 64'(HISTORY_DEPTH) > ring_total) over_run = over_run + 1'b1;
          else over_run = '0;
          ring_total           = ring_total - 64'(level_ring[ring_idx]) + rms64;
          level_ring[ring_idx] = level_t'(rms64);
          ring_idx = (ring_idx == HISTORY_DEPTH - 1) ? 0 : ring_idx + 1;
          want.rms  = level_t'(rms64);
          want.mean = level_t'(mean64);
          want.over = over_run;
          frame_results_q.push_back(want);
          frames_done++;
          energy_sum = '0;
          frame_len  = 0;
        end
      end
    end
    waiting = frame_results_q.size();
  end

endmodule

// ----- tb/tb_frame_rms_over_average_detector_top.sv -----
// testbench top for frame_rms_over_average_detector_top: drives sample items,
// applies output backpressure and gives the verdict
// depends on frdet_pkg, the block itself and frame_rms_checker
`timescale 1ns / 1ps

module tb_frame_rms_over_average_detector_top;
  import frdet_pkg::*;

  localparam int LOUD_FRAMES  = 300;
  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_CYCLES  = 600;
  localparam int DIRECTED_N   = 18;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_frame_end;
  logic                       out_valid;
  logic                       out_stall;
  logic [LEVEL_W-1:0]         out_rms_level;
  logic [LEVEL_W-1:0]         out_mean_level;
  logic [RUN_W-1:0]           out_over_count;

  int mismatches;
  int pending;
  int samples_taken;
  int frames_done;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;

  // edge values, bit patterns, multi-sample frames, a loud and a quiet frame
  logic signed [SAMPLE_W-1:0] directed_samples [DIRECTED_N] = '{
    16'sd0, 16'sh7FFF, 16'sh8000, -16'sd1, 16'sd1,
    16'sh5555, 16'shAAAA, 16'sd100, -16'sd100,
    16'sh8000, 16'sh8000, 16'sh8000,
    16'sd0, 16'sd0, 16'sd0,
    16'sd12345, -16'sd12345, 16'sd7
  };
  logic directed_ends [DIRECTED_N] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b1, 1'b1
  };

  frame_rms_over_average_detector_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_frame_end   (in_frame_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rms_level  (out_rms_level),
    .out_mean_level (out_mean_level),
    .out_over_count (out_over_count)
  );

  frame_rms_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_frame_end   (in_frame_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rms_level  (out_rms_level),
    .out_mean_level (out_mean_level),
    .out_over_count (out_over_count),
    .mismatches     (mismatches),
    .waiting        (pending),
    .samples_taken  (samples_taken),
    .frames_done    (frames_done)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = SAMPLE_W'($urandom);
      4, 5: v = SAMPLE_W'($urandom_range(255));
      6: begin
        case ($urandom_range(3))
          0: v = 16'sh8000;
          1: v = 16'sh7FFF;
          2: v = 16'sd0;
          default: v = -16'sd1;
        endcase
      end
      default: v = SAMPLE_W'($urandom_range(4095));
    endcase
    if ($urandom_range(1) == 1 && v != 16'sh8000) v = -v;
    return v;
  endfunction

  // offer one item at a falling edge and return at the edge that takes it
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_frame_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // result side: random stall, or a long counted hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    int rand_sent;
    int len;
    int pick;
    rand_sent     = 0;
    hold_left     = 0;
    send_idle_pct = 34;
    recv_idle_pct = 73;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_sample     = '0;
    in_frame_end  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_N; i++) send_sample(directed_samples[i], directed_ends[i]);

    // full-scale frames keep the level above the mean long enough to wrap the count
    for (int i = 0; i < LOUD_FRAMES; i++) send_sample(16'sh8000, 1'b1);

    // mostly short frames so the history ring wraps
    send_idle_pct = 73;
    recv_idle_pct = 34;
    while (rand_sent < RANDOM_ITEMS) begin
      if (rand_sent >= RANDOM_ITEMS / 2 && send_idle_pct != 0) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = HOLD_CYCLES;
      end
      pick = $urandom_range(99);
      if (pick < 85) len = 1;
      else if (pick < 97) len = $urandom_range(3, 2);
      else len = $urandom_range(12, 4);
      for (int i = 0; i < len; i++) begin
        send_sample(pick_sample(), i == len - 1);
        rand_sent++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("run covered %0d samples in %0d frames: extreme and patterned samples,",
             samples_taken, frames_done);
    $display("over-count wrap, history ring wrap and a long output hold-off");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
